// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion, off while reset is high.
`define BPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Concurrent assertion that also holds across reset.
`define BPA_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hdl/bpa_pkg.sv -----
// Constants, codes and types of the buddy page allocator.
`default_nettype none
package bpa_pkg;
   localparam int MAX_ORDER = 15;
   localparam int ORDER_W   = 4;
   localparam int PAGE_W    = 15;
   localparam int CNT_W     = 16;
   localparam int WORD_W    = 32;
   localparam int BIT_W     = 5;
   localparam int WIDX_W    = PAGE_W - BIT_W;
   localparam int ADDR_W    = ORDER_W + WIDX_W;
   localparam int MAP_WORDS = (MAX_ORDER + 1) * (1 << WIDX_W);

   localparam logic [CNT_W-1:0] PAGE_SPACE = CNT_W'(1 << PAGE_W);

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_REBUILD = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0] wr_data;
   } mem_req_type;

   // Smallest k with 2^k >= n, for n from 1 to 2^MAX_ORDER.
   function automatic logic [ORDER_W-1:0] order_of(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0]   x;
      logic [ORDER_W-1:0] k;
      x = n - CNT_W'(1);
      k = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (x[i]) begin
            k = ORDER_W'(i + 1);
         end
      end
      return k;
   endfunction
endpackage
`default_nettype wire

// ----- hdl/buddy_page_allocator_core.sv -----
// Buddy page allocator: command port, total_pages register, sequencer and map memory.
// Free: a read and a check per merge step, then one read and write at the end.
// Alloc: a read and a check per map word scanned, up to 1024 words per order, plus a read and write per split.
// Rebuild: clearing pass over all 16384 map memory words, then block writes from order 15 down to 0.
// Reset runs the same clearing pass and rebuild with total_pages = 32768; busy is high
// throughout and no result is shown. Results are single-cycle strobes; no back-pressure.
`default_nettype none
module buddy_page_allocator_core (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [1:0]                   req_cmd,
   input  wire  [bpa_pkg::CNT_W-1:0]    req_request_pages,
   input  wire  [bpa_pkg::PAGE_W-1:0]   req_block_start,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]   rsp_alloc_start,
   output logic [bpa_pkg::CNT_W-1:0]    rsp_avail_pages,
   input  wire                          csr_we,
   input  wire  [bpa_pkg::CNT_W-1:0]    csr_wdata
);
   import bpa_pkg::*;

   logic [CNT_W-1:0]  total_pages_ff;
   mem_req_type       mem_req;
   logic [WORD_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_pages_ff <= PAGE_SPACE;
      end else if (csr_we) begin
         total_pages_ff <= csr_wdata;
      end
   end

   bpa_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_request_pages (req_request_pages),
      .req_block_start   (req_block_start),
      .total_pages       (total_pages_ff),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_alloc_start   (rsp_alloc_start),
      .rsp_avail_pages   (rsp_avail_pages),
      .mem_req           (mem_req),
      .rd_data           (rd_data)
   );

   bpa_map_ram u_map (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (rd_data)
   );
endmodule
`default_nettype wire

// ----- hdl/bpa_map_ram.sv -----
// Free block map: one bit per order and start page, 32 bits to a memory word.
`default_nettype none
module bpa_map_ram (
   input  wire                           clock,
   input  wire bpa_pkg::mem_req_type     req,
   output logic [bpa_pkg::WORD_W-1:0]    rd_data
);
   import bpa_pkg::*;

   logic [WORD_W-1:0] mem [0:MAP_WORDS-1];

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- hdl/bpa_ctrl.sv -----
// Sequencer: search, split, merge and rebuild over the free block map.
`default_nettype none
module bpa_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [1:0]                   req_cmd,
   input  wire  [bpa_pkg::CNT_W-1:0]    req_request_pages,
   input  wire  [bpa_pkg::PAGE_W-1:0]   req_block_start,
   input  wire  [bpa_pkg::CNT_W-1:0]    total_pages,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]   rsp_alloc_start,
   output logic [bpa_pkg::CNT_W-1:0]    rsp_avail_pages,
   output bpa_pkg::mem_req_type         mem_req,
   input  wire  [bpa_pkg::WORD_W-1:0]   rd_data
);
   import bpa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_BUILD, ST_SCAN_RD, ST_SCAN_CHK, ST_SPLIT_RD, ST_SPLIT_WR,
      ST_MERGE_RD, ST_MERGE_CHK, ST_SET_RD, ST_SET_WR
   } state_type;

   state_type          state_ff;
   logic [ADDR_W-1:0]  caddr_ff;
   logic [ORDER_W-1:0] k_ff, ord_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [WIDX_W-1:0]  widx_ff;
   logic [CNT_W-1:0]   base_ff, nreb_ff, count_ff;
   logic               emit_ff, rsp_valid_ff;
   logic [1:0]         status_ff;
   logic [PAGE_W-1:0]  astart_ff;

   logic [CNT_W-1:0]   upper_in;
   logic [PAGE_W-1:0]  buddy_in, ord_bit_in;
   logic [BIT_W-1:0]   low_in;
   logic               size_ok_in;
   logic [ORDER_W-1:0] k_in;
   logic [CNT_W-1:0]   pow_k_in;
   logic [CNT_W:0]     sum_in;

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] b;
      b = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            b = BIT_W'(i);
         end
      end
      return b;
   endfunction

   function automatic logic [WORD_W-1:0] bit_of(input logic [BIT_W-1:0] b);
      return WORD_W'(1) << b;
   endfunction

   assign ord_bit_in = PAGE_W'(1) << ord_ff;
   assign upper_in   = {1'b0, page_ff} + (CNT_W'(1) << ord_ff);
   assign buddy_in   = page_ff ^ ord_bit_in;
   assign low_in     = lowest_bit(rd_data);
   assign size_ok_in = (req_request_pages != '0) && (req_request_pages <= PAGE_SPACE);
   assign k_in       = order_of(req_request_pages);
   assign pow_k_in   = CNT_W'(1) << k_ff;
   assign sum_in     = {1'b0, count_ff} + {1'b0, CNT_W'(1) << k_in};

   always_comb begin
      mem_req = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = caddr_ff;
         end
         ST_BUILD: begin
            mem_req.wr_en   = nreb_ff[ord_ff];
            mem_req.wr_addr = {ord_ff, base_ff[PAGE_W-1:BIT_W]};
            mem_req.wr_data = bit_of(base_ff[BIT_W-1:0]);
         end
         ST_SCAN_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = {ord_ff, widx_ff};
         end
         ST_SCAN_CHK: begin
            mem_req.wr_en   = (rd_data != '0);
            mem_req.wr_addr = {ord_ff, widx_ff};
            mem_req.wr_data = rd_data & ~bit_of(low_in);
         end
         ST_SPLIT_RD: begin
            mem_req.rd_en   = ~upper_in[PAGE_W];
            mem_req.rd_addr = {ord_ff, upper_in[PAGE_W-1:BIT_W]};
         end
         ST_SPLIT_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = {ord_ff, upper_in[PAGE_W-1:BIT_W]};
            mem_req.wr_data = rd_data | bit_of(upper_in[BIT_W-1:0]);
         end
         ST_MERGE_RD: begin
            mem_req.rd_en   = (ord_ff != ORDER_W'(MAX_ORDER));
            mem_req.rd_addr = {ord_ff, buddy_in[PAGE_W-1:BIT_W]};
         end
         ST_MERGE_CHK: begin
            mem_req.wr_en   = rd_data[buddy_in[BIT_W-1:0]];
            mem_req.wr_addr = {ord_ff, buddy_in[PAGE_W-1:BIT_W]};
            mem_req.wr_data = rd_data & ~bit_of(buddy_in[BIT_W-1:0]);
         end
         ST_SET_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = {ord_ff, page_ff[PAGE_W-1:BIT_W]};
         end
         ST_SET_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = {ord_ff, page_ff[PAGE_W-1:BIT_W]};
            mem_req.wr_data = rd_data | bit_of(page_ff[BIT_W-1:0]);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         caddr_ff     <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         status_ff    <= STATUS_OK;
         astart_ff    <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  k_ff      <= k_in;
                  ord_ff    <= k_in;
                  page_ff   <= req_block_start;
                  widx_ff   <= '0;
                  astart_ff <= '0;
                  status_ff <= STATUS_OK;
                  case (req_cmd)
                     CMD_ALLOC: begin
                        if (size_ok_in) begin
                           state_ff <= ST_SCAN_RD;
                        end else begin
                           status_ff    <= STATUS_BAD;
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     CMD_FREE: begin
                        if (size_ok_in) begin
                           count_ff <= sum_in[CNT_W] ? '1 : sum_in[CNT_W-1:0];
                           state_ff <= ST_MERGE_RD;
                        end else begin
                           status_ff    <= STATUS_BAD;
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     CMD_REBUILD: begin
                        caddr_ff <= '0;
                        emit_ff  <= 1'b1;
                        state_ff <= ST_CLEAR;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_CLEAR: begin
               caddr_ff <= caddr_ff + 1'b1;
               if (caddr_ff == ADDR_W'(MAP_WORDS - 1)) begin
                  ord_ff   <= ORDER_W'(MAX_ORDER);
                  base_ff  <= '0;
                  nreb_ff  <= (total_pages > PAGE_SPACE) ? PAGE_SPACE : total_pages;
                  state_ff <= ST_BUILD;
               end
            end
            ST_BUILD: begin
               if (nreb_ff[ord_ff]) begin
                  base_ff <= base_ff + (CNT_W'(1) << ord_ff);
               end
               if (ord_ff == '0) begin
                  count_ff     <= nreb_ff;
                  status_ff    <= STATUS_OK;
                  astart_ff    <= '0;
                  rsp_valid_ff <= emit_ff;
                  state_ff     <= ST_IDLE;
               end else begin
                  ord_ff <= ord_ff - 1'b1;
               end
            end
            ST_SCAN_RD: begin
               state_ff <= ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
               if (rd_data != '0) begin
                  page_ff <= {widx_ff, low_in};
                  if (ord_ff == k_ff) begin
                     astart_ff    <= {widx_ff, low_in};
                     count_ff     <= (count_ff >= pow_k_in) ? count_ff - pow_k_in : '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     ord_ff   <= ord_ff - 1'b1;
                     state_ff <= ST_SPLIT_RD;
                  end
               end else if (widx_ff == '1) begin
                  if (ord_ff == ORDER_W'(MAX_ORDER)) begin
                     status_ff    <= STATUS_NO_FREE;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     ord_ff   <= ord_ff + 1'b1;
                     widx_ff  <= '0;
                     state_ff <= ST_SCAN_RD;
                  end
               end else begin
                  widx_ff  <= widx_ff + 1'b1;
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_SPLIT_RD, ST_SPLIT_WR: begin
               // drop an upper half that lies past the page space
               if (state_ff == ST_SPLIT_RD && !upper_in[PAGE_W]) begin
                  state_ff <= ST_SPLIT_WR;
               end else if (ord_ff == k_ff) begin
                  astart_ff    <= page_ff;
                  count_ff     <= (count_ff >= pow_k_in) ? count_ff - pow_k_in : '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  ord_ff   <= ord_ff - 1'b1;
                  state_ff <= ST_SPLIT_RD;
               end
            end
            ST_MERGE_RD: begin
               state_ff <= (ord_ff == ORDER_W'(MAX_ORDER)) ? ST_SET_RD : ST_MERGE_CHK;
            end
            ST_MERGE_CHK: begin
               if (rd_data[buddy_in[BIT_W-1:0]]) begin
                  page_ff  <= page_ff & ~ord_bit_in;
                  ord_ff   <= ord_ff + 1'b1;
                  state_ff <= ST_MERGE_RD;
               end else begin
                  state_ff <= ST_SET_RD;
               end
            end
            ST_SET_RD: begin
               state_ff <= ST_SET_WR;
            end
            ST_SET_WR: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_alloc_start = astart_ff;
   assign rsp_avail_pages = count_ff;
endmodule
`default_nettype wire

// ----- hdl/bpa_checker.sv -----
// Port-level checks for the buddy page allocator and their bind.
`default_nettype none
`include "assert_macros.svh"
module bpa_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        start,
   input wire                        busy,
   input wire                        rsp_valid,
   input wire [1:0]                  rsp_status,
   input wire [bpa_pkg::PAGE_W-1:0]  rsp_alloc_start
);
   import bpa_pkg::*;

   `BPA_ASSERT_NR(a_reset_busy, clock, reset |=> busy, "not busy after reset")
   `BPA_ASSERT(a_word_idle, clock, reset, rsp_valid |-> !busy, "result word while busy")
   `BPA_ASSERT(a_accept_moves, clock, reset, (start && !busy) |=> (busy || rsp_valid), "command dropped")
   `BPA_ASSERT(a_fail_zero, clock, reset, (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_alloc_start == '0), "start on failure")
endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_alloc_start (rsp_alloc_start)
);
`default_nettype wire
